FILE: rtl/mrf_pkg.sv
// shared types and constants for the mesh relay filter with pairing
package mrf_pkg;

  localparam int SEEN_ENTRIES_DEF = 16;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_TO_LIVE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME     = 2'd2;

  localparam logic [7:0] HEADER_MARKER_RST = 8'd0;
  localparam logic [7:0] TIME_TO_LIVE_RST  = 8'd8;
  localparam logic [7:0] MIN_FRAME_RST     = 8'd6;

  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_PAIR  = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;

  localparam logic [1:0] KIND_DATA = 2'b01;
  localparam logic [1:0] KIND_PAIR = 2'b10;

  localparam logic [15:0] NONCE_DISCONNECT = 16'hffff;

  localparam logic [2:0] ACT_DROP  = 3'd0;
  localparam logic [2:0] ACT_RELAY = 3'd1;
  localparam logic [2:0] ACT_ACK   = 3'd2;
  localparam logic [2:0] ACT_PAIR  = 3'd3;
  localparam logic [2:0] ACT_NONE  = 3'd4;

  localparam logic [3:0] RSN_NONE    = 4'd0;
  localparam logic [3:0] RSN_SHORT   = 4'd1;
  localparam logic [3:0] RSN_HEADER  = 4'd2;
  localparam logic [3:0] RSN_KIND    = 4'd3;
  localparam logic [3:0] RSN_NETWORK = 4'd4;
  localparam logic [3:0] RSN_HOPS    = 4'd5;
  localparam logic [3:0] RSN_OWN     = 4'd6;
  localparam logic [3:0] RSN_DUP     = 4'd7;
  localparam logic [3:0] RSN_FOREIGN = 4'd8;

  typedef struct packed {
    logic [7:0] pkt_id;
    logic [7:0] origin;
  } seen_key_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  drop_reason;
    logic [7:0]  network;
    logic [7:0]  origin;
    logic [7:0]  pkt_id;
    logic [7:0]  hops;
    logic [15:0] nonce;
    logic        reporting;
  } result_t;

endpackage

FILE: rtl/mrf_seen_cell.sv
// one cell of the duplicate cache: holds a key, compares, shifts to its neighbor
module mrf_seen_cell
  import mrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      shift_en,
  input  seen_key_t key_in,
  input  seen_key_t prev_key,
  output seen_key_t key_out,
  output logic      hit
);

  seen_key_t key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (shift_en) begin
      key_r <= prev_key;
    end
  end

  assign key_out = key_r;
  assign hit     = (key_r == key_in);

endmodule

FILE: rtl/mrf_out_buf.sv
// output register with skid stage for result words
module mrf_out_buf
  import mrf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_word,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_word
);

  logic    main_valid_r;
  logic    skid_valid_r;
  result_t main_r;
  result_t skid_r;
  logic    take;

  assign take = main_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_valid_r || take) begin
        main_r <= push_word;
      end else begin
        skid_r <= push_word;
      end
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_word  = main_r;

endmodule

FILE: rtl/mesh_relay_filter_with_pairing.sv
// top level of the mesh relay filter with pairing
//
// usage: one header word enters on the in_ channel (in_valid / in_stall) and
// exactly one result word leaves on the out_ channel (out_valid / out_stall).
// registers are written through cfg_wr_en, cfg_index and cfg_wdata while idle.
// the result word is registered in the output buffer. throughput: one word
// per cycle while in_stall is low; the decision, the duplicate lookup in the
// row of cache cells and the state update all settle in the accepting cycle.
// the duplicate cache is a row of SEEN_ENTRIES cells that shift toward the
// end when a new key is inserted, so the oldest key falls out first.
// reset (rst_n low, synchronous) clears identity, pending nonce, reporting,
// all cache cells and the output buffer, and loads register defaults.
// when out_stall is held, one more word is taken into a skid stage; after
// that in_stall rises until the receiver drains the buffer.
module mesh_relay_filter_with_pairing
  import mrf_pkg::*;
#(
  parameter int SEEN_ENTRIES = SEEN_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [8:0]            in_frame_length,
  input  logic [7:0]            in_header_byte,
  input  logic [1:0]            in_packet_kind,
  input  logic [7:0]            in_frame_network,
  input  logic [7:0]            in_hops_left,
  input  logic [7:0]            in_origin_node,
  input  logic [7:0]            in_frame_pkt_id,
  input  logic [15:0]           in_frame_nonce,
  input  logic [15:0]           in_fresh_nonce,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_action,
  output logic [3:0]            out_drop_reason,
  output logic [7:0]            out_network,
  output logic [7:0]            out_origin,
  output logic [7:0]            out_pkt_id,
  output logic [7:0]            out_hops,
  output logic [15:0]           out_nonce,
  output logic                  out_reporting_enabled
);

  logic [7:0]  header_marker_r;
  logic [7:0]  time_to_live_r;
  logic [7:0]  min_frame_r;

  logic [7:0]  my_node_r,  my_node_nxt;
  logic [7:0]  my_net_r,   my_net_nxt;
  logic [15:0] pend_r,     pend_nxt;
  logic        report_r,   report_nxt;

  logic        in_acc;
  logic        buf_full;
  logic        insert;
  logic        seen_hit;
  seen_key_t   key;
  seen_key_t   cell_key [SEEN_ENTRIES];
  logic [SEEN_ENTRIES-1:0] cell_hit;
  result_t     res;
  result_t     out_word;
  logic        hops_low;

  assign in_stall = buf_full;
  assign in_acc   = in_valid && !buf_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_marker_r <= HEADER_MARKER_RST;
      time_to_live_r  <= TIME_TO_LIVE_RST;
      min_frame_r     <= MIN_FRAME_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HEADER_MARKER: header_marker_r <= cfg_wdata;
        CFG_TIME_TO_LIVE:  time_to_live_r  <= cfg_wdata;
        CFG_MIN_FRAME:     min_frame_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // duplicate cache row
  assign key.pkt_id = in_frame_pkt_id;
  assign key.origin = in_origin_node;

  for (genvar i = 0; i < SEEN_ENTRIES; i++) begin : g_cell
    seen_key_t prev;
    if (i == 0) begin : g_head
      assign prev = key;
    end else begin : g_body
      assign prev = cell_key[i-1];
    end
    mrf_seen_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (insert),
      .key_in   (key),
      .prev_key (prev),
      .key_out  (cell_key[i]),
      .hit      (cell_hit[i])
    );
  end

  assign seen_hit = |cell_hit;
  assign hops_low = (in_hops_left[7:1] == 7'd0);

  // decision
  always_comb begin
    my_node_nxt = my_node_r;
    my_net_nxt  = my_net_r;
    pend_nxt    = pend_r;
    report_nxt  = report_r;
    insert      = 1'b0;
    res         = '0;
    res.action  = ACT_NONE;
    case (in_req_type)
      REQ_PAIR: begin
        pend_nxt      = in_fresh_nonce;
        res.action    = ACT_PAIR;
        res.hops      = time_to_live_r;
        res.nonce     = in_fresh_nonce;
      end
      REQ_LOAD: begin
        my_net_nxt  = in_frame_network;
        my_node_nxt = in_origin_node;
        if (in_origin_node != 8'd0 && in_frame_network != 8'd0) begin
          report_nxt = 1'b1;
        end else begin
          pend_nxt   = in_fresh_nonce;
          res.action = ACT_PAIR;
          res.hops   = time_to_live_r;
          res.nonce  = in_fresh_nonce;
        end
      end
      REQ_FRAME: begin
        res.action = ACT_DROP;
        if (in_frame_length <= {1'b0, min_frame_r}) begin
          res.drop_reason = RSN_SHORT;
        end else if (in_header_byte != header_marker_r) begin
          res.drop_reason = RSN_HEADER;
        end else if (in_packet_kind == KIND_DATA) begin
          if (in_frame_network != my_net_r) begin
            res.drop_reason = RSN_NETWORK;
          end else if (hops_low) begin
            res.drop_reason = RSN_HOPS;
          end else if (in_origin_node == my_node_r) begin
            res.drop_reason = RSN_OWN;
          end else if (seen_hit) begin
            res.drop_reason = RSN_DUP;
          end else begin
            insert      = in_acc;
            res.action  = ACT_RELAY;
            res.network = in_frame_network;
            res.origin  = in_origin_node;
            res.pkt_id  = in_frame_pkt_id;
            res.hops    = in_hops_left - 8'd1;
          end
        end else if (in_packet_kind == KIND_PAIR) begin
          if (pend_r != 16'd0 && in_frame_network != 8'd0 &&
              in_frame_nonce == pend_r) begin
            my_node_nxt = in_frame_pkt_id;
            my_net_nxt  = in_frame_network;
            pend_nxt    = 16'd0;
            report_nxt  = 1'b1;
            res.action  = ACT_ACK;
            res.network = in_frame_network;
            res.origin  = in_frame_pkt_id;
            res.hops    = in_hops_left;
          end else if (my_net_r != 8'd0 && in_frame_network != 8'd0 &&
                       my_net_r != in_frame_network) begin
            res.drop_reason = RSN_FOREIGN;
          end else if (in_origin_node == my_node_r &&
                       in_frame_nonce == NONCE_DISCONNECT) begin
            report_nxt  = 1'b0;
            my_node_nxt = 8'd0;
            my_net_nxt  = 8'd0;
            pend_nxt    = in_fresh_nonce;
            res.action  = ACT_PAIR;
            res.hops    = time_to_live_r;
            res.nonce   = in_fresh_nonce;
          end else if (hops_low) begin
            res.drop_reason = RSN_HOPS;
          end else begin
            res.action  = ACT_RELAY;
            res.network = in_frame_network;
            res.origin  = in_origin_node;
            res.pkt_id  = in_frame_pkt_id;
            res.hops    = in_hops_left - 8'd1;
            res.nonce   = in_frame_nonce;
          end
        end else begin
          res.drop_reason = RSN_KIND;
        end
      end
      default: ;
    endcase
    res.reporting = report_nxt;
  end

  // node state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_node_r <= 8'd0;
      my_net_r  <= 8'd0;
      pend_r    <= 16'd0;
      report_r  <= 1'b0;
    end else if (in_acc) begin
      my_node_r <= my_node_nxt;
      my_net_r  <= my_net_nxt;
      pend_r    <= pend_nxt;
      report_r  <= report_nxt;
    end
  end

  mrf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_word (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_action            = out_word.action;
  assign out_drop_reason       = out_word.drop_reason;
  assign out_network           = out_word.network;
  assign out_origin            = out_word.origin;
  assign out_pkt_id            = out_word.pkt_id;
  assign out_hops              = out_word.hops;
  assign out_nonce             = out_word.nonce;
  assign out_reporting_enabled = out_word.reporting;

endmodule
